// ===== hw/rtl/timer_table_scheduler_assert.svh =====
// Assertion helpers shared by the timer scheduler RTL.
`ifndef TIMER_TABLE_SCHEDULER_ASSERT_SVH
`define TIMER_TABLE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTS_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tts_pkg.sv =====
package tts_pkg;

    localparam int DELAY_BITS  = 32;
    localparam int STAMP_BITS  = 32;
    localparam int STATUS_BITS = 2;

    typedef enum logic [2:0] {
        F_ADD_TO = 3'd0,
        F_ADD_IV = 3'd1,
        F_CANCEL = 3'd2,
        F_PAUSE  = 3'd3,
        F_RESUME = 3'd4,
        F_TICK   = 3'd5
    } t_func;

    typedef logic [STATUS_BITS-1:0] t_status;
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FIRED = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_MISS  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_ERD  = 5'b01000,
        S_EWR  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        M_CANCEL = 3'd0,
        M_PAUSE  = 3'd1,
        M_RESUME = 3'd2,
        M_DUE    = 3'd3,
        M_PICK   = 3'd4,
        M_SUM    = 3'd5
    } t_mode;

endpackage

// ===== hw/rtl/tts_in_if.sv =====
interface tts_in_if import tts_pkg::*; #(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 32
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            func;
    logic [TIME_BITS-1:0]  now_time;
    logic [DELAY_BITS-1:0] delay;
    logic [ID_BITS-1:0]    target_id;

    modport source(output valid, func, now_time, delay, target_id, input ready);
    modport sink(input valid, func, now_time, delay, target_id, output ready);
endinterface

// ===== hw/rtl/tts_out_if.sv =====
interface tts_out_if import tts_pkg::*; #(
    parameter int TIME_BITS = 48,
    parameter int ID_BITS   = 32,
    parameter int CNT_BITS  = 5
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     result_id;
    logic                   rearmed;
    logic                   next_valid;
    logic [TIME_BITS-1:0]   next_expiry;
    logic [CNT_BITS-1:0]    active_count;
    logic                   last;

    modport source(output valid, status, result_id, rearmed, next_valid, next_expiry,
                   active_count, last, input ready);
    modport sink(input valid, status, result_id, rearmed, next_valid, next_expiry,
                 active_count, last, output ready);
endinterface

// ===== hw/rtl/tts_ram.sv =====
module tts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/timer_table_scheduler.sv =====
// Timer table scheduler.
// Requests arrive on i_in (valid/ready); each request is one transaction carrying
// func, now_time, delay and target_id. Results leave on o_out, one or more per
// request, the final one flagged by last. Every result of a request carries the
// table summary (next_valid, next_expiry, active_count) after that request.
// Timer entries live in a single-port-write, registered-read slot RAM; results of
// a request are queued in a small result RAM and streamed out once the summary
// scan is done. An add takes a summary scan; a cancel, or a pause or resume that
// changes the paused flag, takes an action scan and a summary scan; an unpaused
// tick takes a due scan, a pick scan and an update per fired timer, a last pick
// scan and a summary scan. Each result then moves to the output register through
// S_ERD and S_EWR. The slot RAM scans read one entry per cycle. i_in.ready is
// high only while no request is in work; the output register lets the next
// request enter while the final result still waits. A stalled receiver holds the
// output register and the block waits for it. Reset clears all valid bits, the
// paused flag and the id and stamp counters; no clearing pass is needed.
module timer_table_scheduler
    import tts_pkg::*;
#(
    parameter int MAX_TIMERS = 16,
    parameter int TIME_BITS  = 48,
    parameter int ID_BITS    = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tts_in_if.sink   i_in,
    tts_out_if.source o_out
);
`include "timer_table_scheduler_assert.svh"

    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int LW = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;
    localparam int SW = LW + 1;
    localparam logic [SW-1:0] TMAX = SW'({TIME_BITS{1'b1}});

    typedef struct packed {
        logic [ID_BITS-1:0]    ident;
        logic [TIME_BITS-1:0]  expiry;
        logic [DELAY_BITS-1:0] period;
        logic [LW-1:0]         left;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [ID_BITS-1:0] id;
        logic               rearmed;
    } t_res;

    localparam int EW = $bits(t_entry);
    localparam int RW = $bits(t_res);

    function automatic logic [TIME_BITS-1:0] f_sat(input logic [TIME_BITS-1:0] a,
                                                   input logic [LW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s > TMAX) begin
            return {TIME_BITS{1'b1}};
        end
        return s[TIME_BITS-1:0];
    endfunction

    function automatic logic f_earlier(input t_entry a, input t_entry b);
        return (a.expiry < b.expiry) || (a.expiry == b.expiry && a.stamp < b.stamp);
    endfunction

    t_state                r_state;
    t_mode                 r_mode;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [MAX_TIMERS-1:0] r_due;
    logic                  r_paused;
    logic [ID_BITS-1:0]    r_id;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [TIME_BITS-1:0]  r_now;
    logic [ID_BITS-1:0]    r_tgt;
    logic [IW:0]           r_ra;
    logic                  r_rv;
    logic [IW-1:0]         r_ri;
    logic                  r_hit;
    logic                  r_bhave;
    logic [IW-1:0]         r_bidx;
    t_entry                r_bent;
    logic [CW-1:0]         r_nres;
    logic [IW-1:0]         r_ei;
    logic [CW-1:0]         r_cnt;
    logic                  r_have;
    logic [TIME_BITS-1:0]  r_best;

    logic                  r_ov;
    t_status               r_ost;
    logic [ID_BITS-1:0]    r_oid;
    logic                  r_ore;
    logic                  r_onv;
    logic [TIME_BITS-1:0]  r_onx;
    logic [CW-1:0]         r_ocnt;
    logic                  r_olast;

    logic                  w_in_acc;
    logic                  w_free_ok;
    logic [IW-1:0]         w_free_idx;
    logic                  w_scan_end;
    logic                  w_out_free;
    logic                  w_ent_ok;
    t_entry                w_ent;
    logic [EW-1:0]         w_srd;
    logic                  w_sw_en;
    logic [IW-1:0]         w_sw_addr;
    t_entry                w_sw_data;
    logic                  w_push;
    t_res                  w_push_data;
    logic [RW-1:0]         w_qrd;
    t_res                  w_q;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_scan_end = (r_ra == (IW+1)'(MAX_TIMERS)) && !r_rv;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_ent      = t_entry'(w_srd);
    assign w_ent_ok   = r_rv && r_valid[r_ri];
    assign w_q        = t_res'(w_qrd);

    always_comb begin
        w_free_ok  = 1'b0;
        w_free_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok  = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_sw_en     = 1'b0;
        w_sw_addr   = r_ri;
        w_sw_data   = w_ent;
        w_push      = 1'b0;
        w_push_data = '{status: ST_DONE, id: '0, rearmed: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        F_ADD_TO, F_ADD_IV: begin
                            w_push = 1'b1;
                            if (w_free_ok) begin
                                w_sw_en          = 1'b1;
                                w_sw_addr        = w_free_idx;
                                w_sw_data.ident  = r_id;
                                w_sw_data.expiry = f_sat(i_in.now_time, LW'(i_in.delay));
                                w_sw_data.period = (i_in.func == F_ADD_IV) ? i_in.delay : '0;
                                w_sw_data.left   = LW'(i_in.delay);
                                w_sw_data.stamp  = r_stamp;
                                w_push_data.id   = r_id;
                            end else begin
                                w_push_data.status = ST_FULL;
                            end
                        end
                        F_CANCEL: w_push = 1'b0;
                        F_PAUSE:  w_push = r_paused;
                        F_RESUME: w_push = !r_paused;
                        F_TICK:   w_push = r_paused;
                        default:  w_push = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_ent_ok && r_mode == M_PAUSE) begin
                    w_sw_en        = 1'b1;
                    w_sw_data.left = (w_ent.expiry > r_now) ? LW'(w_ent.expiry - r_now) : '0;
                end
                if (w_ent_ok && r_mode == M_RESUME) begin
                    w_sw_en          = 1'b1;
                    w_sw_data.expiry = f_sat(r_now, w_ent.left);
                end
                if (w_scan_end) begin
                    case (r_mode)
                        M_CANCEL: begin
                            w_push             = 1'b1;
                            w_push_data.status = r_hit ? ST_DONE : ST_MISS;
                            w_push_data.id     = r_tgt;
                        end
                        M_PAUSE, M_RESUME: w_push = 1'b1;
                        M_PICK:            w_push = !r_bhave && (r_nres == '0);
                        default:           w_push = 1'b0;
                    endcase
                end
            end
            S_UPD: begin
                w_push              = 1'b1;
                w_push_data.status  = ST_FIRED;
                w_push_data.id      = r_bent.ident;
                w_push_data.rearmed = (r_bent.period != '0);
                w_sw_addr           = r_bidx;
                w_sw_data           = r_bent;
                w_sw_data.expiry    = f_sat(r_now, LW'(r_bent.period));
                w_sw_data.stamp     = r_stamp;
                w_sw_en             = (r_bent.period != '0);
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    tts_ram #(.DEPTH(MAX_TIMERS), .WIDTH(EW)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_sw_en),
        .i_waddr(w_sw_addr),
        .i_wdata(EW'(w_sw_data)),
        .i_raddr(r_ra[IW-1:0]),
        .o_rdata(w_srd)
    );

    tts_ram #(.DEPTH(MAX_TIMERS), .WIDTH(RW)) u_res_ram (
        .i_clk  (i_clk),
        .i_we   (w_push),
        .i_waddr(r_nres[IW-1:0]),
        .i_wdata(RW'(w_push_data)),
        .i_raddr(r_ei),
        .o_rdata(w_qrd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_paused <= 1'b0;
            r_id     <= '0;
            r_stamp  <= '0;
            r_nres   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (w_push) begin
                r_nres <= r_nres + CW'(1);
            end
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_now   <= i_in.now_time;
                        r_tgt   <= i_in.target_id;
                        r_hit   <= 1'b0;
                        r_ra    <= '0;
                        r_rv    <= 1'b0;
                        r_bhave <= 1'b0;
                        r_cnt   <= '0;
                        r_have  <= 1'b0;
                        r_best  <= '0;
                        r_state <= S_SCAN;
                        r_mode  <= M_SUM;
                        case (i_in.func)
                            F_ADD_TO, F_ADD_IV: begin
                                if (w_free_ok) begin
                                    r_valid[w_free_idx] <= 1'b1;
                                    r_id                <= r_id + ID_BITS'(1);
                                    r_stamp             <= r_stamp + STAMP_BITS'(1);
                                end
                            end
                            F_CANCEL: r_mode <= M_CANCEL;
                            F_PAUSE: begin
                                if (!r_paused) begin
                                    r_paused <= 1'b1;
                                    r_mode   <= M_PAUSE;
                                end
                            end
                            F_RESUME: begin
                                if (r_paused) begin
                                    r_paused <= 1'b0;
                                    r_mode   <= M_RESUME;
                                end
                            end
                            F_TICK: begin
                                if (!r_paused) begin
                                    r_mode <= M_DUE;
                                end
                            end
                            default: r_mode <= M_SUM;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_ra != (IW+1)'(MAX_TIMERS)) begin
                        r_ri <= r_ra[IW-1:0];
                        r_ra <= r_ra + (IW+1)'(1);
                        r_rv <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        case (r_mode)
                            M_CANCEL: begin
                                if (w_ent_ok && w_ent.ident == r_tgt) begin
                                    r_valid[r_ri] <= 1'b0;
                                    r_hit         <= 1'b1;
                                end
                            end
                            M_DUE: r_due[r_ri] <= w_ent_ok && (w_ent.expiry <= r_now);
                            M_PICK: begin
                                if (r_due[r_ri] && (!r_bhave || f_earlier(w_ent, r_bent))) begin
                                    r_bhave <= 1'b1;
                                    r_bidx  <= r_ri;
                                    r_bent  <= w_ent;
                                end
                            end
                            M_SUM: begin
                                if (w_ent_ok) begin
                                    r_cnt <= r_cnt + CW'(1);
                                    if (!r_have || w_ent.expiry < r_best) begin
                                        r_best <= w_ent.expiry;
                                        r_have <= 1'b1;
                                    end
                                end
                            end
                            default: r_hit <= r_hit;
                        endcase
                    end
                    if (w_scan_end) begin
                        r_ra    <= '0;
                        r_bhave <= 1'b0;
                        r_cnt   <= '0;
                        r_have  <= 1'b0;
                        r_best  <= '0;
                        case (r_mode)
                            M_DUE: r_mode <= M_PICK;
                            M_PICK: begin
                                if (r_bhave) begin
                                    r_state <= S_UPD;
                                    r_bhave <= 1'b1;
                                end else begin
                                    r_mode <= M_SUM;
                                end
                            end
                            M_SUM: begin
                                r_state <= S_ERD;
                                r_ei    <= '0;
                                r_cnt   <= r_cnt;
                                r_have  <= r_have;
                                r_best  <= r_best;
                            end
                            default: r_mode <= M_SUM;
                        endcase
                    end
                end
                S_UPD: begin
                    r_due[r_bidx] <= 1'b0;
                    if (r_bent.period != '0) begin
                        r_stamp <= r_stamp + STAMP_BITS'(1);
                    end else begin
                        r_valid[r_bidx] <= 1'b0;
                    end
                    r_bhave <= 1'b0;
                    r_mode  <= M_PICK;
                    r_state <= S_SCAN;
                end
                S_ERD: begin
                    r_state <= S_EWR;
                end
                S_EWR: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_ost   <= w_q.status;
                        r_oid   <= w_q.id;
                        r_ore   <= w_q.rearmed;
                        r_onv   <= r_have && !r_paused;
                        r_onx   <= r_paused ? '0 : r_best;
                        r_ocnt  <= r_cnt;
                        r_olast <= (CW'(r_ei) + CW'(1) == r_nres);
                        if (CW'(r_ei) + CW'(1) == r_nres) begin
                            r_nres  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ei    <= r_ei + IW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_ost;
    assign o_out.result_id    = r_oid;
    assign o_out.rearmed      = r_ore;
    assign o_out.next_valid   = r_onv;
    assign o_out.next_expiry  = r_onx;
    assign o_out.active_count = r_ocnt;
    assign o_out.last         = r_olast;

    // A request always queues at least one result before streaming starts.
    `TTS_CHECK(a_emit_nonempty, r_state == S_ERD, r_nres != '0, "empty result stream")
    `TTS_CHECK(a_nres_bound, 1'b1, r_nres <= CW'(MAX_TIMERS), "result queue overflow")
    // Timers marked due for this tick must still be live in the table.
    `TTS_CHECK(a_due_live, r_state == S_SCAN && r_mode == M_PICK, (r_due & ~r_valid) == '0,
               "due timer not valid")
    `TTS_CHECK_NEXT(a_accept_busy, w_in_acc, r_state != S_IDLE, "accepted request not taken")

endmodule

// ===== bench/timer_table_scheduler_test.sv =====
`timescale 1ns / 1ps

module timer_table_scheduler_test;
    import tts_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int TBITS     = 48;
    localparam int IBITS     = 32;
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [TBITS-1:0] TIME_MAX = {TBITS{1'b1}};
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        t_status          status;
        logic [IBITS-1:0] result_id;
        logic             rearmed;
        logic             next_valid;
        logic [TBITS-1:0] next_expiry;
        logic [4:0]       active_count;
        logic             last;
    } t_result;

    logic clk;
    logic rst_n;

    tts_in_if  #(.TIME_BITS(TBITS), .ID_BITS(IBITS)) in_bus ();
    tts_out_if #(.TIME_BITS(TBITS), .ID_BITS(IBITS)) out_bus ();

    timer_table_scheduler #(
        .MAX_TIMERS(NUM_SLOTS),
        .TIME_BITS (TBITS),
        .ID_BITS   (IBITS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Shadow of the timer table.
    bit               tm_valid  [NUM_SLOTS];
    logic [IBITS-1:0] tm_ident  [NUM_SLOTS];
    logic [TBITS-1:0] tm_expiry [NUM_SLOTS];
    logic [31:0]      tm_period [NUM_SLOTS];
    logic [TBITS-1:0] tm_left   [NUM_SLOTS];
    logic [31:0]      tm_stamp  [NUM_SLOTS];
    bit               tm_paused;
    logic [IBITS-1:0] next_ident;
    logic [31:0]      next_stamp;

    t_result pending_results[$];
    int      error_count;
    int      sender_idle_pct;
    int      receiver_idle_pct;
    int      hold_off_cycles;
    logic [TBITS-1:0] clock_now;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [TBITS-1:0] add_sat(logic [TBITS-1:0] a, logic [TBITS-1:0] b);
        logic [TBITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TBITS] ? TIME_MAX : sum[TBITS-1:0];
    endfunction

    task automatic predict_request(logic [2:0] func, logic [TBITS-1:0] now,
                                   logic [31:0] delay, logic [IBITS-1:0] target);
        t_result          batch[$];
        t_result          r;
        int               free_slot;
        int               pick;
        bit               hit;
        bit               due[NUM_SLOTS];
        int               cnt;
        bit               have;
        logic [TBITS-1:0] best;
        r = '{default: '0};
        if (func == F_ADD_TO || func == F_ADD_IV) begin
            free_slot = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (!tm_valid[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
                r.status = ST_FULL;
            end else begin
                tm_valid[free_slot]  = 1'b1;
                tm_ident[free_slot]  = next_ident;
                tm_expiry[free_slot] = add_sat(now, {16'd0, delay});
                tm_period[free_slot] = (func == F_ADD_IV) ? delay : 32'd0;
                tm_left[free_slot]   = {16'd0, delay};
                tm_stamp[free_slot]  = next_stamp;
                next_stamp++;
                r.status    = ST_DONE;
                r.result_id = next_ident;
                next_ident++;
            end
            batch = {batch, r};
        end else if (func == F_CANCEL) begin
            hit = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (tm_valid[i] && tm_ident[i] == target) begin
                    tm_valid[i] = 1'b0;
                    hit = 1'b1;
                end
            r.status    = hit ? ST_DONE : ST_MISS;
            r.result_id = target;
            batch = {batch, r};
        end else if (func == F_PAUSE) begin
            if (!tm_paused) begin
                tm_paused = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tm_valid[i])
                        tm_left[i] = (tm_expiry[i] > now) ? tm_expiry[i] - now : '0;
            end
            batch = {batch, r};
        end else if (func == F_RESUME) begin
            if (tm_paused) begin
                tm_paused = 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tm_valid[i]) tm_expiry[i] = add_sat(now, tm_left[i]);
            end
            batch = {batch, r};
        end else if (func == F_TICK && !tm_paused) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                due[i] = tm_valid[i] && tm_expiry[i] <= now;
            forever begin
                pick = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (due[i] && (pick < 0 || tm_expiry[i] < tm_expiry[pick] ||
                        (tm_expiry[i] == tm_expiry[pick] && tm_stamp[i] < tm_stamp[pick])))
                        pick = i;
                if (pick < 0) break;
                due[pick]   = 1'b0;
                r.status    = ST_FIRED;
                r.result_id = tm_ident[pick];
                if (tm_period[pick] != 0) begin
                    tm_expiry[pick] = add_sat(now, {16'd0, tm_period[pick]});
                    tm_stamp[pick]  = next_stamp;
                    next_stamp++;
                    r.rearmed = 1'b1;
                end else begin
                    tm_valid[pick] = 1'b0;
                    r.rearmed = 1'b0;
                end
                batch = {batch, r};
            end
            if (batch.size() == 0) begin
                r = '{default: '0};
                batch = {batch, r};
            end
        end else begin
            batch = {batch, r};
        end

        cnt  = 0;
        have = 1'b0;
        best = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tm_valid[i]) begin
                cnt++;
                if (!have || tm_expiry[i] < best) begin
                    best = tm_expiry[i];
                    have = 1'b1;
                end
            end
        if (tm_paused) begin
            have = 1'b0;
            best = '0;
        end
        foreach (batch[k]) begin
            batch[k].next_valid   = have;
            batch[k].next_expiry  = best;
            batch[k].active_count = cnt[4:0];
            batch[k].last         = (k == batch.size() - 1);
            pending_results = {pending_results, batch[k]};
        end
    endtask

    // Offers one request and returns once the transaction has been accepted.
    task automatic send_request(logic [2:0] func, logic [TBITS-1:0] now,
                                logic [31:0] delay, logic [IBITS-1:0] target);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.func      <= func;
        in_bus.now_time  <= now;
        in_bus.delay     <= delay;
        in_bus.target_id <= target;
        do @(posedge clk); while (!in_bus.ready);
        predict_request(func, now, delay, target);
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_bus.ready   <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result exp_r;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual id %h status %0d",
                         $time, out_bus.result_id, out_bus.status);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_bus.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, out_bus.status);
                    error_count++;
                end
                if (out_bus.result_id !== exp_r.result_id) begin
                    $display("%0t: result_id expected %h actual %h", $time,
                             exp_r.result_id, out_bus.result_id);
                    error_count++;
                end
                if (out_bus.rearmed !== exp_r.rearmed) begin
                    $display("%0t: rearmed expected %b actual %b", $time,
                             exp_r.rearmed, out_bus.rearmed);
                    error_count++;
                end
                if (out_bus.next_valid !== exp_r.next_valid) begin
                    $display("%0t: next_valid expected %b actual %b", $time,
                             exp_r.next_valid, out_bus.next_valid);
                    error_count++;
                end
                if (out_bus.next_expiry !== exp_r.next_expiry) begin
                    $display("%0t: next_expiry expected %h actual %h", $time,
                             exp_r.next_expiry, out_bus.next_expiry);
                    error_count++;
                end
                if (out_bus.active_count !== exp_r.active_count) begin
                    $display("%0t: active_count expected %0d actual %0d", $time,
                             exp_r.active_count, out_bus.active_count);
                    error_count++;
                end
                if (out_bus.last !== exp_r.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_r.last, out_bus.last);
                    error_count++;
                end
            end
        end
    end

    task automatic test_add_and_full();
        send_request(F_ADD_TO, '0, 32'd0, '0);
        send_request(F_ADD_IV, 48'd10, 32'hFFFF_FFFF, '0);
        send_request(F_ADD_TO, TIME_MAX, 32'hFFFF_FFFF, '0);
        for (int i = 0; i < 14; i++) send_request(F_ADD_TO, 48'd20, 32'd5, '0);
        send_request(F_ADD_IV, 48'd20, 32'd1, '0);
    endtask

    task automatic test_cancel();
        send_request(F_CANCEL, 48'd20, 32'd0, 32'd3);
        send_request(F_CANCEL, 48'd20, 32'd0, 32'hFFFF_FFFF);
        send_request(F_ADD_IV, 48'd20, 32'd0, '0);
    endtask

    task automatic test_pause_resume();
        send_request(F_PAUSE, 48'd22, 32'd0, '0);
        send_request(F_PAUSE, 48'd30, 32'd0, '0);
        send_request(F_TICK, 48'd1000, 32'd0, '0);
        send_request(F_RESUME, 48'd100, 32'd0, '0);
        send_request(F_RESUME, 48'd200, 32'd0, '0);
    endtask

    task automatic test_tick_order();
        send_request(F_TICK, 48'd50, 32'd0, '0);
        send_request(F_TICK, 48'd120, 32'd0, '0);
        send_request(F_TICK, TIME_MAX, 32'd0, '0);
        send_request(F_TICK, '0, 32'd0, '0);
    endtask

    task automatic test_spare_selectors();
        send_request(FUNC_SPARE_LO, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(FUNC_SPARE_HI, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic send_random(int count);
        logic [2:0]       func;
        logic [31:0]      delay;
        logic [IBITS-1:0] target;
        int               pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 36) func = ($urandom_range(1)) ? F_ADD_IV : F_ADD_TO;
            else if (pick < 50) func = F_CANCEL;
            else if (pick < 56) func = F_PAUSE;
            else if (pick < 63) func = F_RESUME;
            else if (pick < 97) func = F_TICK;
            else func = ($urandom_range(1)) ? FUNC_SPARE_HI : FUNC_SPARE_LO;

            // Time mostly moves forward in small steps; now and then it jumps anywhere.
            pick = $urandom_range(99);
            if (pick < 4) clock_now = {16'($urandom_range(16'hFFFF)), $urandom()};
            else if (pick < 6) clock_now = TIME_MAX - TBITS'($urandom_range(300));
            else if (pick < 8) clock_now = TBITS'($urandom_range(50));
            else clock_now = add_sat(clock_now, TBITS'($urandom_range(60)));

            pick = $urandom_range(99);
            if (pick < 8) delay = $urandom();
            else if (pick < 15) delay = 32'd0;
            else delay = $urandom_range(150);

            if ($urandom_range(99) < 75 && next_ident != 0)
                target = next_ident - 1 - $urandom_range(20);
            else
                target = $urandom();
            send_request(func, clock_now, delay, target);
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_cycles   = 600;
        for (int i = 0; i < 12; i++) begin
            clock_now = add_sat(clock_now, TBITS'(3));
            send_request((i % 3 == 2) ? F_TICK : F_ADD_IV, clock_now, 32'd2, '0);
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.func       = F_TICK;
        in_bus.now_time   = '0;
        in_bus.delay      = '0;
        in_bus.target_id  = '0;
        out_bus.ready     = 1'b0;
        error_count       = 0;
        hold_off_cycles   = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        clock_now         = 48'd200;
        tm_paused         = 1'b0;
        next_ident        = '0;
        next_stamp        = '0;
        foreach (tm_valid[i]) tm_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_and_full();
        test_cancel();
        test_pause_resume();
        test_tick_order();
        test_spare_selectors();

        sender_idle_pct   = 29;
        receiver_idle_pct = 45;
        send_random(142);
        sender_idle_pct   = 45;
        receiver_idle_pct = 29;
        send_random(142);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random(142);
        test_backpressure();

        wait_idle();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
